// ----- rtl/tcgr_pkg.sv -----
// Shared types, constants and the color palette of the text cell glyph rasterizer.
package tcgr_pkg;

   localparam int GLYPH_HEIGHT_DEF = 16;
   localparam int PIXEL_BYTES      = 4;
   localparam int STORE_AW         = 12;
   localparam int STORE_DEPTH      = 1 << STORE_AW;
   localparam int Y0_W             = 12;   // text row * glyph height, at most 255 * 16
   localparam int CSR_IDX_W        = 2;
   localparam int CSR_DATA_W       = 32;

   localparam logic OP_DRAW       = 1'b0;
   localparam logic OP_FONT_WRITE = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_DRAW_ENABLE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LINE_PITCH  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_BASE  = 2'd2;

   typedef enum logic [2:0] {
      CMD_HOLD      = 3'd0,
      CMD_MUL       = 3'd1,
      CMD_ADD_COL   = 3'd2,
      CMD_ADD_BASE  = 3'd3,
      CMD_NEXT_PAIR = 3'd4,
      CMD_NEXT_ROW  = 3'd5
   } addr_cmd_type;

   typedef struct packed {
      addr_cmd_type    cmd;
      logic [Y0_W-1:0] y0;
      logic [8:0]      col;
   } addr_ctl_type;

   function automatic logic [31:0] palette_argb(input logic [3:0] idx);
      logic [31:0] c;
      case (idx)
         4'd0:    c = 32'hFF000000;
         4'd1:    c = 32'hFF0000AA;
         4'd2:    c = 32'hFF00AA00;
         4'd3:    c = 32'hFF00AAAA;
         4'd4:    c = 32'hFFAA0000;
         4'd5:    c = 32'hFFAA00AA;
         4'd6:    c = 32'hFFAA5500;
         4'd7:    c = 32'hFFAAAAAA;
         4'd8:    c = 32'hFF555555;
         4'd9:    c = 32'hFF5555FF;
         4'd10:   c = 32'hFF55FF55;
         4'd11:   c = 32'hFF55FFFF;
         4'd12:   c = 32'hFFFF5555;
         4'd13:   c = 32'hFFFF55FF;
         4'd14:   c = 32'hFFFFFF00;
         4'd15:   c = 32'hFFFFFFFF;
         default: c = 32'hFF000000;
      endcase
      return c;
   endfunction

endpackage

// ----- rtl/tcgr_glyph_ram.sv -----
// Glyph store: 4096 x 8 memory, one write port and one registered read port.
module tcgr_glyph_ram (
   input  logic                          clock,
   input  logic                          we,
   input  logic [tcgr_pkg::STORE_AW-1:0] waddr,
   input  logic [7:0]                    wdata,
   input  logic                          re,
   input  logic [tcgr_pkg::STORE_AW-1:0] raddr,
   output logic [7:0]                    rdata
);
   import tcgr_pkg::*;

   logic [7:0] mem [STORE_DEPTH];
   logic [7:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ----- rtl/tcgr_addr_unit.sv -----
// Shared address unit: one multiplier and one 32-bit adder stepped by the sequencer.
module tcgr_addr_unit (
   input  logic                   clock,
   input  tcgr_pkg::addr_ctl_type ctl,
   input  logic [15:0]            line_pitch,
   input  logic [31:0]            frame_base,
   output logic [31:0]            addr
);
   import tcgr_pkg::*;

   logic [31:0] acc_ff, acc_in;
   logic [31:0] line_ff, line_in;
   logic [31:0] opa, opb, sum;
   logic [27:0] prod;

   assign prod = 28'(ctl.y0) * 28'(line_pitch);
   assign sum  = opa + opb;

   always_comb begin
      opa     = acc_ff;
      opb     = '0;
      acc_in  = acc_ff;
      line_in = line_ff;
      case (ctl.cmd)
         CMD_MUL: begin
            acc_in = 32'(prod);
         end
         CMD_ADD_COL: begin
            opb    = 32'({ctl.col, 5'b0});   // column * 8 pixels * 4 bytes
            acc_in = sum;
         end
         CMD_ADD_BASE: begin
            opb     = frame_base;
            acc_in  = sum;
            line_in = sum;
         end
         CMD_NEXT_PAIR: begin
            opb    = 32'(2 * PIXEL_BYTES);
            acc_in = sum;
         end
         CMD_NEXT_ROW: begin
            opa     = line_ff;
            opb     = 32'(line_pitch);
            acc_in  = sum;
            line_in = sum;
         end
         default: begin
            acc_in = acc_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      acc_ff  <= acc_in;
      line_ff <= line_in;
   end

   assign addr = acc_ff;

endmodule

// ----- rtl/text_cell_glyph_rasterizer_top.sv -----
// Top level: channel handshakes, config registers, cell sequencer and result register.
//
//  channel | ports                               | dir | handshake
//  req     | req_operation .. req_font_byte      | in  | req_valid / req_ready
//  rsp     | rsp_write_address, pixel_pair, last | out | rsp_valid / rsp_ready
//  csr     | csr_we, csr_index, csr_wdata        | in  | write on csr_we, no wait
//
// A font write goes straight into the glyph RAM. A draw runs three setup steps of the shared
// address unit, then per glyph row one glyph RAM read followed by four pixel-pair beats.
// A stalled rsp beat holds the sequencer in place; req stays not ready until the cell is done.
// Synchronous reset clears the sequencer, the output valid and the config registers.
module text_cell_glyph_rasterizer_top #(
   parameter int GLYPH_HEIGHT = tcgr_pkg::GLYPH_HEIGHT_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            req_operation,
   input  logic [8:0]                      req_cell_column,
   input  logic [7:0]                      req_cell_row,
   input  logic [15:0]                     req_cell_value,
   input  logic [11:0]                     req_font_address,
   input  logic [7:0]                      req_font_byte,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [31:0]                     rsp_write_address,
   output logic [63:0]                     rsp_pixel_pair,
   output logic                            rsp_last_write,
   input  logic                            csr_we,
   input  logic [tcgr_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [tcgr_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import tcgr_pkg::*;

   localparam int RW = (GLYPH_HEIGHT > 1) ? $clog2(GLYPH_HEIGHT) : 1;
   localparam logic [RW-1:0] LAST_ROW = RW'(GLYPH_HEIGHT - 1);

   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_MUL   = 6'b000010,
      S_COL   = 6'b000100,
      S_BASE  = 6'b001000,
      S_FETCH = 6'b010000,
      S_EMIT  = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   logic        draw_enable_ff;
   logic [15:0] line_pitch_ff;
   logic [31:0] frame_base_ff;

   logic [Y0_W-1:0]     y0_ff, y0_in;
   logic [8:0]          col_ff, col_in;
   logic [STORE_AW-1:0] glyph_base_ff, glyph_base_in;
   logic [31:0]         fg_ff, fg_in, bg_ff, bg_in;
   logic [RW-1:0]       row_ff, row_in;
   logic [1:0]          pair_ff, pair_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_addr_ff, rsp_addr_in;
   logic [63:0] rsp_pair_ff, rsp_pair_in;
   logic        rsp_last_ff, rsp_last_in;

   addr_ctl_type ctl;
   logic [31:0]  cur_addr;
   logic         ram_we, ram_re;
   logic [7:0]   glyph_bits;
   logic         out_free;
   logic         req_beat;
   logic [2:0]   lbit, rbit;

   assign req_ready = (state_ff == S_IDLE);
   assign req_beat  = req_valid && req_ready;
   assign ram_we    = req_beat && (req_operation == OP_FONT_WRITE);
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign lbit      = 3'd7 - {pair_ff, 1'b0};
   assign rbit      = 3'd6 - {pair_ff, 1'b0};

   always_ff @(posedge clock) begin
      if (reset) begin
         draw_enable_ff <= 1'b0;
         line_pitch_ff  <= '0;
         frame_base_ff  <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_DRAW_ENABLE: draw_enable_ff <= csr_wdata[0];
            CSR_LINE_PITCH:  line_pitch_ff  <= csr_wdata[15:0];
            CSR_FRAME_BASE:  frame_base_ff  <= csr_wdata[31:0];
            default:         draw_enable_ff <= draw_enable_ff;
         endcase
      end
   end

   always_comb begin
      state_in      = state_ff;
      y0_in         = y0_ff;
      col_in        = col_ff;
      glyph_base_in = glyph_base_ff;
      fg_in         = fg_ff;
      bg_in         = bg_ff;
      row_in        = row_ff;
      pair_in       = pair_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_addr_in   = rsp_addr_ff;
      rsp_pair_in   = rsp_pair_ff;
      rsp_last_in   = rsp_last_ff;
      ram_re        = 1'b0;
      ctl.cmd       = CMD_HOLD;
      ctl.y0        = y0_ff;
      ctl.col       = col_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_beat && req_operation == OP_DRAW && draw_enable_ff) begin
               state_in      = S_MUL;
               y0_in         = Y0_W'(req_cell_row * GLYPH_HEIGHT);
               col_in        = req_cell_column;
               glyph_base_in = STORE_AW'(req_cell_value[7:0] * GLYPH_HEIGHT);
               fg_in         = palette_argb(req_cell_value[11:8]);
               bg_in         = palette_argb(req_cell_value[15:12]);
               row_in        = '0;
               pair_in       = '0;
            end
         end
         S_MUL: begin
            ctl.cmd  = CMD_MUL;
            state_in = S_COL;
         end
         S_COL: begin
            ctl.cmd  = CMD_ADD_COL;
            state_in = S_BASE;
         end
         S_BASE: begin
            ctl.cmd  = CMD_ADD_BASE;
            state_in = S_FETCH;
         end
         S_FETCH: begin
            ram_re   = 1'b1;
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_addr_in  = cur_addr;
               rsp_pair_in  = {(glyph_bits[rbit] ? fg_ff : bg_ff),
                               (glyph_bits[lbit] ? fg_ff : bg_ff)};
               rsp_last_in  = (row_ff == LAST_ROW) && (pair_ff == 2'd3);
               pair_in      = pair_ff + 2'd1;
               if (pair_ff == 2'd3) begin
                  if (row_ff == LAST_ROW) begin
                     state_in = S_IDLE;
                  end else begin
                     ctl.cmd  = CMD_NEXT_ROW;
                     row_in   = row_ff + 1'b1;
                     state_in = S_FETCH;
                  end
               end else begin
                  ctl.cmd = CMD_NEXT_PAIR;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      y0_ff         <= y0_in;
      col_ff        <= col_in;
      glyph_base_ff <= glyph_base_in;
      fg_ff         <= fg_in;
      bg_ff         <= bg_in;
      row_ff        <= row_in;
      pair_ff       <= pair_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_pair_ff   <= rsp_pair_in;
      rsp_last_ff   <= rsp_last_in;
   end

   tcgr_glyph_ram u_glyph_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (req_font_address),
      .wdata (req_font_byte),
      .re    (ram_re),
      .raddr (glyph_base_ff + STORE_AW'(row_ff)),
      .rdata (glyph_bits)
   );

   tcgr_addr_unit u_addr_unit (
      .clock      (clock),
      .ctl        (ctl),
      .line_pitch (line_pitch_ff),
      .frame_base (frame_base_ff),
      .addr       (cur_addr)
   );

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_write_address = rsp_addr_ff;
   assign rsp_pixel_pair    = rsp_pair_ff;
   assign rsp_last_write    = rsp_last_ff;

   // a blocked result slot freezes the running address
   a_addr_holds_on_stall: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EMIT && rsp_valid_ff && !rsp_ready) |=> $stable(cur_addr))
      else $error("address moved while result slot was blocked");

   // font writes never start the cell sequencer
   a_font_write_stays_idle: assert property (@(posedge clock) disable iff (reset)
      (req_beat && req_operation == OP_FONT_WRITE) |=> (state_ff == S_IDLE))
      else $error("font write left the idle state");

   // each glyph row starts on its leftmost pair
   a_fetch_row_start: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FETCH) |-> (pair_ff == 2'd0))
      else $error("glyph fetch with pair index not at row start");

endmodule
